FILE: rtl/core/tdc_pkg.sv
// shared types, constants and helpers of the time and date counter
package tdc_pkg;

  // field widths
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 14;
  // year modulo 100 and century modulo 4
  localparam int unsigned YMOD_W = 7;
  localparam int unsigned CENT_W = 2;

  // counter limits
  localparam logic [SEC_W-1:0]  SEC_LAST   = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_LAST  = 5'd23;
  localparam logic [MON_W-1:0]  MON_FIRST  = 4'd1;
  localparam logic [MON_W-1:0]  MON_FEB    = 4'd2;
  localparam logic [MON_W-1:0]  MON_APR    = 4'd4;
  localparam logic [MON_W-1:0]  MON_JUN    = 4'd6;
  localparam logic [MON_W-1:0]  MON_SEP    = 4'd9;
  localparam logic [MON_W-1:0]  MON_NOV    = 4'd11;
  localparam logic [MON_W-1:0]  MON_LAST   = 4'd12;
  localparam logic [DAY_W-1:0]  DAY_FIRST  = 5'd1;
  localparam logic [DAY_W-1:0]  DAY_31     = 5'd31;
  localparam logic [DAY_W-1:0]  DAY_30     = 5'd30;
  localparam logic [DAY_W-1:0]  DAY_29     = 5'd29;
  localparam logic [DAY_W-1:0]  DAY_28     = 5'd28;
  localparam logic [YEAR_W-1:0] YEAR_LAST  = 14'd9999;
  localparam logic [YMOD_W-1:0] YMOD_LAST  = 7'd99;

  // y / 100 as (y * 5243) >> 19, exact for y up to 9999
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [YEAR_W-1:0] CENTURY  = 14'd100;

  // item codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } tdc_op_e;

  // one input item
  typedef struct packed {
    tdc_op_e             opcode;
    logic [YEAR_W-1:0]   load_year;
    logic [MON_W-1:0]    load_month;
    logic [DAY_W-1:0]    load_day;
    logic [HOUR_W-1:0]   load_hour;
    logic [MIN_W-1:0]    load_minute;
    logic [SEC_W-1:0]    load_second;
  } tdc_in_t;

  // counter state, with the year kept split for the leap rule
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [YMOD_W-1:0]   ymod;
    logic [CENT_W-1:0]   cent;
    logic [MON_W-1:0]    month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [SEC_W-1:0]    second;
  } tdc_state_t;

  // status flags of one item
  typedef struct packed {
    logic day_rolled;
    logic load_error;
  } tdc_flags_t;

  // one result item
  typedef struct packed {
    logic [YEAR_W-1:0]   cur_year;
    logic [MON_W-1:0]    cur_month;
    logic [DAY_W-1:0]    cur_day;
    logic [HOUR_W-1:0]   cur_hour;
    logic [MIN_W-1:0]    cur_minute;
    logic [SEC_W-1:0]    cur_second;
    tdc_flags_t          flags;
  } tdc_res_t;

  // days in a month for a given leap flag
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_30;
      MON_FEB:                            len = leap ? DAY_29 : DAY_28;
      default:                            len = DAY_31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/tdc_in_if.sv
// input channel of the time and date counter
interface tdc_in_if;
  import tdc_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [YEAR_W-1:0] load_year;
  logic [MON_W-1:0]  load_month;
  logic [DAY_W-1:0]  load_day;
  logic [HOUR_W-1:0] load_hour;
  logic [MIN_W-1:0]  load_minute;
  logic [SEC_W-1:0]  load_second;

  modport source (
    output valid, opcode, load_year, load_month, load_day, load_hour,
           load_minute, load_second,
    input  ready
  );

  modport sink (
    input  valid, opcode, load_year, load_month, load_day, load_hour,
           load_minute, load_second,
    output ready
  );
endinterface

FILE: rtl/core/tdc_out_if.sv
// result channel of the time and date counter
interface tdc_out_if;
  import tdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [YEAR_W-1:0] cur_year;
  logic [MON_W-1:0]  cur_month;
  logic [DAY_W-1:0]  cur_day;
  logic [HOUR_W-1:0] cur_hour;
  logic [MIN_W-1:0]  cur_minute;
  logic [SEC_W-1:0]  cur_second;
  logic              day_rolled;
  logic              load_error;

  modport source (
    output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
           cur_second, day_rolled, load_error,
    input  ready
  );

  modport sink (
    input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
           cur_second, day_rolled, load_error,
    output ready
  );
endinterface

FILE: rtl/core/tdc_year_split.sv
// splits a loaded year into year modulo 100 and century modulo 4
module tdc_year_split (
  input  logic [tdc_pkg::YEAR_W-1:0] year_i,
  output logic [tdc_pkg::YMOD_W-1:0] ymod_o,
  output logic [tdc_pkg::CENT_W-1:0] cent_o
);
  import tdc_pkg::*;

  localparam int unsigned PROD_W = YEAR_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [YMOD_W-1:0] quot;
  logic [YEAR_W-1:0] quot_x100;

  // quotient by reciprocal multiply, then remainder
  assign prod      = PROD_W'(year_i) * PROD_W'(RECIP_100);
  assign quot      = prod[RECIP_SHIFT +: YMOD_W];
  assign quot_x100 = YEAR_W'(quot) * CENTURY;
  assign ymod_o    = YMOD_W'(year_i - quot_x100);
  assign cent_o    = quot[CENT_W-1:0];
endmodule

FILE: rtl/core/tdc_step.sv
// next counter state and flags for one item
module tdc_step (
  input  tdc_pkg::tdc_state_t state_i,
  input  tdc_pkg::tdc_in_t    item_i,
  output tdc_pkg::tdc_state_t state_o,
  output tdc_pkg::tdc_flags_t flags_o
);
  import tdc_pkg::*;

  logic              sec_wrap, min_wrap, hour_wrap;
  logic              leap;
  logic [DAY_W-1:0]  mlen;
  logic [YEAR_W-1:0] ld_year;
  logic [YMOD_W-1:0] ld_ymod;
  logic [CENT_W-1:0] ld_cent;
  logic              bad_month, bad_day;

  // leap rule from the split year
  assign leap = (state_i.ymod != '0) ? (state_i.year[1:0] == 2'b00)
                                     : (state_i.cent == '0);
  assign mlen = month_len(state_i.month, leap);

  // carry chain of the tick
  assign sec_wrap  = state_i.second >= SEC_LAST;
  assign min_wrap  = sec_wrap && (state_i.minute >= MIN_LAST);
  assign hour_wrap = min_wrap && (state_i.hour >= HOUR_LAST);

  // load checks
  assign ld_year   = (item_i.load_year > YEAR_LAST) ? '0 : item_i.load_year;
  assign bad_month = (item_i.load_month == '0) || (item_i.load_month > MON_LAST);
  assign bad_day   = (item_i.load_day == '0);

  tdc_year_split u_split (
    .year_i (ld_year),
    .ymod_o (ld_ymod),
    .cent_o (ld_cent)
  );

  // next state
  always_comb begin
    state_o = state_i;
    flags_o = '0;
    if (item_i.opcode == OP_LOAD) begin
      state_o.year   = ld_year;
      state_o.ymod   = ld_ymod;
      state_o.cent   = ld_cent;
      state_o.month  = bad_month ? MON_FIRST : item_i.load_month;
      state_o.day    = bad_day ? DAY_FIRST : item_i.load_day;
      state_o.hour   = (item_i.load_hour > HOUR_LAST) ? '0 : item_i.load_hour;
      state_o.minute = (item_i.load_minute > MIN_LAST) ? '0 : item_i.load_minute;
      state_o.second = (item_i.load_second > SEC_LAST) ? '0 : item_i.load_second;
      flags_o.load_error = bad_month || bad_day;
    end else begin
      state_o.second = sec_wrap ? '0 : state_i.second + 1'b1;
      if (sec_wrap) begin
        state_o.minute = min_wrap ? '0 : state_i.minute + 1'b1;
      end
      if (min_wrap) begin
        state_o.hour = hour_wrap ? '0 : state_i.hour + 1'b1;
      end
      if (hour_wrap) begin
        flags_o.day_rolled = 1'b1;
        // date advance
        if (state_i.day < mlen) begin
          state_o.day = state_i.day + 1'b1;
        end else begin
          state_o.day = DAY_FIRST;
          if (state_i.month >= MON_LAST) begin
            state_o.month = MON_FIRST;
            if (state_i.year >= YEAR_LAST) begin
              state_o.year = '0;
              state_o.ymod = '0;
              state_o.cent = '0;
            end else begin
              state_o.year = state_i.year + 1'b1;
              if (state_i.ymod >= YMOD_LAST) begin
                state_o.ymod = '0;
                state_o.cent = state_i.cent + 1'b1;
              end else begin
                state_o.ymod = state_i.ymod + 1'b1;
              end
            end
          end else begin
            state_o.month = state_i.month + 1'b1;
          end
        end
      end
    end
  end
endmodule

FILE: rtl/core/time_and_date_counter_unit.sv
// top level of the time and date counter
// Time-of-day and Gregorian calendar counter. A tick item advances the time
// by one second, carrying through minutes and hours into the date; a load
// item sets date and time, clamping bad fields. Every item returns one result
// with the full date and time, a day-rollover flag and a load-error flag.
// The block takes one item per cycle while results are taken: an item is
// held in the input register, the counter update runs in a single pass of
// carry logic from there into the state and result registers, and a result
// is offered there until it is taken; a stalled result holds back new items.
// The loaded year is split for the leap rule by one small constant multiply
// on that same pass. There is no clearing pass after reset; the counters
// start at 00:00:00 on day 1 of month 1, year 0.
module time_and_date_counter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdc_in_if.sink     in_i,
  tdc_out_if.source  out_o
);
  import tdc_pkg::*;

  tdc_in_t    item_q, item_d;
  logic       item_valid_q, item_valid_d;
  tdc_state_t state_q, state_d, state_next;
  tdc_flags_t flags_next;
  tdc_res_t   res_q, res_d;
  logic       res_valid_q, res_valid_d;
  logic       advance;

  // handshake: the input register drains into the result register
  assign advance    = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;

  // input register
  always_comb begin
    item_d       = item_q;
    item_valid_d = item_valid_q;
    if (in_i.ready) begin
      item_valid_d = in_i.valid;
      if (in_i.valid) begin
        item_d.opcode      = tdc_op_e'(in_i.opcode);
        item_d.load_year   = in_i.load_year;
        item_d.load_month  = in_i.load_month;
        item_d.load_day    = in_i.load_day;
        item_d.load_hour   = in_i.load_hour;
        item_d.load_minute = in_i.load_minute;
        item_d.load_second = in_i.load_second;
      end
    end
  end

  tdc_step u_step (
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_next),
    .flags_o (flags_next)
  );

  // state and result registers
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (advance) begin
      state_d          = state_next;
      res_d.cur_year   = state_next.year;
      res_d.cur_month  = state_next.month;
      res_d.cur_day    = state_next.day;
      res_d.cur_hour   = state_next.hour;
      res_d.cur_minute = state_next.minute;
      res_d.cur_second = state_next.second;
      res_d.flags      = flags_next;
      res_valid_d      = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= '{month: MON_FIRST, day: DAY_FIRST, default: '0};
    end else begin
      item_valid_q <= item_valid_d;
      res_valid_q  <= res_valid_d;
      state_q      <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.cur_year   = res_q.cur_year;
  assign out_o.cur_month  = res_q.cur_month;
  assign out_o.cur_day    = res_q.cur_day;
  assign out_o.cur_hour   = res_q.cur_hour;
  assign out_o.cur_minute = res_q.cur_minute;
  assign out_o.cur_second = res_q.cur_second;
  assign out_o.day_rolled = res_q.flags.day_rolled;
  assign out_o.load_error = res_q.flags.load_error;

  // time counters stay in range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.hour <= HOUR_LAST) && (state_q.minute <= MIN_LAST) &&
    (state_q.second <= SEC_LAST))
    else $error("time counter out of range");

  // date counters stay in range
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.month >= MON_FIRST) && (state_q.month <= MON_LAST) &&
    (state_q.day >= DAY_FIRST) && (state_q.year <= YEAR_LAST))
    else $error("date counter out of range");

  // split year tracks the year
  a_year_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(state_q.ymod) == 32'(state_q.year) % 100) &&
    (32'(state_q.cent) == (32'(state_q.year) / 100) % 4))
    else $error("split year out of step with year");

  // full pipe with a stalled result takes no new item
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_o.ready && item_valid_q) |-> !in_i.ready)
    else $error("item accepted while pipe is stalled");

  // a day rollover always lands on midnight
  a_roll_midnight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.flags.day_rolled) |->
      ((res_q.cur_hour == '0) && (res_q.cur_minute == '0) &&
       (res_q.cur_second == '0) && !res_q.flags.load_error))
    else $error("day rollover away from midnight");
endmodule
